### hw/rtl/assert_macros.svh
// assertion macros shared by the scaler rtl
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition a at an edge implies condition b at the same edge
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// condition a at an edge implies condition b at the following edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

### hw/rtl/nnis_pkg.sv
// types and constants for the nearest-neighbour image scaler
// no dependencies
package nnis_pkg;

   localparam int COL_W  = 12;
   localparam int DIM_W  = 16;
   localparam int PIX_W  = 24;
   localparam int IDX_W  = 8;
   localparam int ROW_PROD_W = 2 * DIM_W;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   // register indexes
   localparam logic [IDX_W-1:0] REG_IN_WIDTH   = 8'd0;
   localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = 8'd1;
   localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = 8'd2;
   localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_MUL,
      ST_COL_SCAN,
      ST_PIX_READ,
      ST_ROW_MUL,
      ST_ROW_SETTLE,
      ST_RESULT
   } state_type;

   // outcome of the row bookkeeping check
   typedef struct packed {
      logic pending;
      logic wrap;
   } row_status_type;

endpackage

### hw/rtl/nnis_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module nnis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/nnis_row_check.sv
// row bookkeeping: does the last complete input row owe another output row
// depends on nnis_pkg; products are registered on start, then compared combinationally
module nnis_row_check (
   input  logic                        clock,
   input  logic                        start,
   input  logic [nnis_pkg::DIM_W-1:0]  rows_emitted,
   input  logic [nnis_pkg::DIM_W-1:0]  push_row,
   input  logic [nnis_pkg::DIM_W-1:0]  eff_in_height,
   input  logic [nnis_pkg::DIM_W-1:0]  eff_out_height,
   output nnis_pkg::row_status_type    status
);

   logic [nnis_pkg::ROW_PROD_W-1:0] emitted_prod_ff;
   logic [nnis_pkg::ROW_PROD_W-1:0] pushed_prod_ff;
   logic pending;

   always_ff @(posedge clock) begin
      if (start) begin
         emitted_prod_ff <= nnis_pkg::ROW_PROD_W'(rows_emitted)
                            * nnis_pkg::ROW_PROD_W'(eff_in_height);
         pushed_prod_ff  <= nnis_pkg::ROW_PROD_W'(eff_out_height)
                            * nnis_pkg::ROW_PROD_W'(push_row);
      end
   end

   assign pending        = (rows_emitted < eff_out_height)
                           && (emitted_prod_ff < pushed_prod_ff);
   assign status.pending = pending;
   assign status.wrap    = !pending && (push_row >= eff_in_height);

endmodule

### hw/rtl/nearest_neighbor_image_scaler.sv
// nearest-neighbour image scaler top level: command decode, counters, line store
// a push that completes a row also runs the row check; a pull first steps past skipped source
// columns, then reads the store, and runs the row check when it ends an output row
// one item at a time: a new command is taken only when the fsm is back in idle
// reset: synchronous active-high; registers return to 1, counters to 0, store not cleared
module nearest_neighbor_image_scaler #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [7:0]                  req_in_blue,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_red,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_accepted,
   output logic [7:0]                  rsp_out_blue,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_red,
   output logic                        rsp_row_end,
   output logic                        rsp_frame_end,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [nnis_pkg::IDX_W-1:0]  csr_index,
   input  logic [nnis_pkg::DIM_W-1:0]  csr_data
);

`include "assert_macros.svh"

   localparam int CW  = nnis_pkg::COL_W;
   localparam int DW  = nnis_pkg::DIM_W;
   localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   // column index wide enough for both the 12-bit counters and the store address
   localparam int XW  = (AW > CW) ? AW : CW;
   // largest width the 12-bit register can express after clamping
   localparam int MW_CLAMP = (MAX_WIDTH > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_WIDTH;
   localparam int PP_W = DW + CW;          // pixels_emitted * in_width
   localparam int PT_W = DW + CW + 1;      // out_width * (source_column + 1)

   // configuration registers
   logic [CW-1:0] in_width_ff,   in_width_in;
   logic [DW-1:0] in_height_ff,  in_height_in;
   logic [DW-1:0] out_width_ff,  out_width_in;
   logic [DW-1:0] out_height_ff, out_height_in;

   // progress counters
   nnis_pkg::state_type state_ff, state_in;
   logic [CW-1:0] push_col_ff,   push_col_in;
   logic [DW-1:0] push_row_ff,   push_row_in;
   logic [DW-1:0] rows_emit_ff,  rows_emit_in;
   logic [DW-1:0] pix_emit_ff,   pix_emit_in;
   logic [CW-1:0] src_col_ff,    src_col_in;
   logic          pending_ff,    pending_in;
   logic          rsp_valid_ff,  rsp_valid_in;

   // column scan products
   logic [PP_W-1:0] prod_p_ff, prod_p_in;
   logic [PT_W-1:0] prod_t_ff, prod_t_in;

   // staged result and output register
   logic          res_acc_ff,   res_acc_in;
   logic [7:0]    res_blue_ff,  res_blue_in;
   logic [7:0]    res_green_ff, res_green_in;
   logic [7:0]    res_red_ff,   res_red_in;
   logic          res_rend_ff,  res_rend_in;
   logic          res_fend_ff,  res_fend_in;
   logic          rsp_acc_ff,   rsp_blue_unused;
   logic [7:0]    rsp_blue_ff,  rsp_green_ff, rsp_red_ff;
   logic          rsp_rend_ff,  rsp_fend_ff;
   logic          rsp_load;

   // effective dimensions, zero acts as one; input width also clamped to MW_CLAMP
   logic [CW-1:0] eff_iw, width_nz;
   logic [DW-1:0] eff_ih, eff_ow, eff_oh;

   // line store port signals
   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [nnis_pkg::PIX_W-1:0]  ram_wr_data, ram_rd_data;
   logic [XW-1:0]               push_col_wide, src_col_wide;
   logic                        push_in_range;

   // row check
   logic                        row_start;
   nnis_pkg::row_status_type    row_status;

   // scratch values
   logic [CW-1:0] col_next;
   logic [CW:0]   src_next;
   logic [DW-1:0] pix_next, rows_next;
   logic          req_xfer, rsp_xfer;

   assign width_nz = (in_width_ff == '0) ? CW'(1) : in_width_ff;
   assign eff_iw   = (width_nz > CW'(MW_CLAMP)) ? CW'(MW_CLAMP) : width_nz;
   assign eff_ih   = (in_height_ff  == '0) ? DW'(1) : in_height_ff;
   assign eff_ow   = (out_width_ff  == '0) ? DW'(1) : out_width_ff;
   assign eff_oh   = (out_height_ff == '0) ? DW'(1) : out_height_ff;

   assign push_col_wide = XW'(push_col_ff);
   assign src_col_wide  = XW'(src_col_ff);
   assign push_in_range = (XW + 1)'(push_col_wide) < (XW + 1)'(MAX_WIDTH);
   assign ram_wr_addr   = push_col_wide[AW-1:0];
   assign ram_rd_addr   = src_col_wide[AW-1:0];
   assign ram_wr_data   = {req_in_red, req_in_green, req_in_blue};

   // handshakes, both held off while in reset
   assign req_stall = reset || (state_ff != nnis_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = !reset && (state_ff == nnis_pkg::ST_IDLE);

   // register writes, only taken while the block is idle
   always_comb begin
      in_width_in   = in_width_ff;
      in_height_in  = in_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            nnis_pkg::REG_IN_WIDTH:   in_width_in   = csr_data[CW-1:0];
            nnis_pkg::REG_IN_HEIGHT:  in_height_in  = csr_data;
            nnis_pkg::REG_OUT_WIDTH:  out_width_in  = csr_data;
            nnis_pkg::REG_OUT_HEIGHT: out_height_in = csr_data;
            default: ;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      push_col_in  = push_col_ff;
      push_row_in  = push_row_ff;
      rows_emit_in = rows_emit_ff;
      pix_emit_in  = pix_emit_ff;
      src_col_in   = src_col_ff;
      pending_in   = pending_ff;
      prod_p_in    = prod_p_ff;
      prod_t_in    = prod_t_ff;
      res_acc_in   = res_acc_ff;
      res_blue_in  = res_blue_ff;
      res_green_in = res_green_ff;
      res_red_in   = res_red_ff;
      res_rend_in  = res_rend_ff;
      res_fend_in  = res_fend_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      row_start    = 1'b0;
      rsp_load     = 1'b0;
      col_next     = push_col_ff + CW'(1);
      src_next     = {1'b0, src_col_ff} + (CW + 1)'(1);
      pix_next     = pix_emit_ff + DW'(1);
      rows_next    = rows_emit_ff + DW'(1);

      case (state_ff)
         nnis_pkg::ST_IDLE: begin
            if (req_xfer) begin
               // default result: nothing returned
               res_acc_in   = 1'b0;
               res_blue_in  = '0;
               res_green_in = '0;
               res_red_in   = '0;
               res_rend_in  = 1'b0;
               res_fend_in  = 1'b0;
               state_in     = nnis_pkg::ST_RESULT;
               if (req_command == nnis_pkg::CMD_PUSH) begin
                  if (!pending_ff) begin
                     // push taken: store pixel, advance column
                     ram_wr_en  = push_in_range;
                     res_acc_in = 1'b1;
                     if (col_next >= eff_iw) begin
                        // input row complete
                        push_col_in = '0;
                        push_row_in = push_row_ff + DW'(1);
                        pix_emit_in = '0;
                        src_col_in  = '0;
                        state_in    = nnis_pkg::ST_ROW_MUL;
                     end else begin
                        push_col_in = col_next;
                     end
                  end
               end else if (pending_ff) begin
                  state_in = nnis_pkg::ST_COL_MUL;
               end
            end
         end

         nnis_pkg::ST_COL_MUL: begin
            prod_p_in = PP_W'(pix_emit_ff) * PP_W'(eff_iw);
            prod_t_in = PT_W'(eff_ow) * PT_W'(src_next);
            state_in  = nnis_pkg::ST_COL_SCAN;
         end

         nnis_pkg::ST_COL_SCAN: begin
            // step past source columns that this output column has left behind
            if ((src_next < (CW + 1)'(eff_iw)) && (PT_W'(prod_p_ff) >= prod_t_ff)) begin
               src_col_in = src_next[CW-1:0];
               prod_t_in  = prod_t_ff + PT_W'(eff_ow);
            end else begin
               ram_rd_en = 1'b1;
               state_in  = nnis_pkg::ST_PIX_READ;
            end
         end

         nnis_pkg::ST_PIX_READ: begin
            res_acc_in   = 1'b1;
            res_blue_in  = ram_rd_data[7:0];
            res_green_in = ram_rd_data[15:8];
            res_red_in   = ram_rd_data[23:16];
            state_in     = nnis_pkg::ST_RESULT;
            if (pix_next >= eff_ow) begin
               // output row complete
               res_rend_in  = 1'b1;
               res_fend_in  = (rows_next >= eff_oh);
               pix_emit_in  = '0;
               src_col_in   = '0;
               rows_emit_in = rows_next;
               state_in     = nnis_pkg::ST_ROW_MUL;
            end else begin
               pix_emit_in = pix_next;
            end
         end

         nnis_pkg::ST_ROW_MUL: begin
            row_start = 1'b1;
            state_in  = nnis_pkg::ST_ROW_SETTLE;
         end

         nnis_pkg::ST_ROW_SETTLE: begin
            pending_in = row_status.pending;
            if (row_status.wrap) begin
               // frame finished, start over
               push_row_in  = '0;
               rows_emit_in = '0;
            end
            state_in = nnis_pkg::ST_RESULT;
         end

         nnis_pkg::ST_RESULT: begin
            // hand the staged result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = nnis_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = nnis_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_xfer ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nnis_pkg::ST_IDLE;
         in_width_ff   <= CW'(1);
         in_height_ff  <= DW'(1);
         out_width_ff  <= DW'(1);
         out_height_ff <= DW'(1);
         push_col_ff   <= '0;
         push_row_ff   <= '0;
         rows_emit_ff  <= '0;
         pix_emit_ff   <= '0;
         src_col_ff    <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_width_ff   <= in_width_in;
         in_height_ff  <= in_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         push_col_ff   <= push_col_in;
         push_row_ff   <= push_row_in;
         rows_emit_ff  <= rows_emit_in;
         pix_emit_ff   <= pix_emit_in;
         src_col_ff    <= src_col_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_p_ff    <= prod_p_in;
      prod_t_ff    <= prod_t_in;
      res_acc_ff   <= res_acc_in;
      res_blue_ff  <= res_blue_in;
      res_green_ff <= res_green_in;
      res_red_ff   <= res_red_in;
      res_rend_ff  <= res_rend_in;
      res_fend_ff  <= res_fend_in;
      if (rsp_load) begin
         rsp_acc_ff   <= res_acc_ff;
         rsp_blue_ff  <= res_blue_ff;
         rsp_green_ff <= res_green_ff;
         rsp_red_ff   <= res_red_ff;
         rsp_rend_ff  <= res_rend_ff;
         rsp_fend_ff  <= res_fend_ff;
      end
   end

   assign rsp_blue_unused = 1'b0;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_acc_ff | rsp_blue_unused;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_row_end   = rsp_rend_ff;
   assign rsp_frame_end = rsp_fend_ff;

   // line store, one pixel per input column
   nnis_ram #(
      .WIDTH (nnis_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // pending-row decision after a row boundary
   nnis_row_check u_row_check (
      .clock          (clock),
      .start          (row_start),
      .rows_emitted   (rows_emit_ff),
      .push_row       (push_row_ff),
      .eff_in_height  (eff_ih),
      .eff_out_height (eff_oh),
      .status         (row_status)
   );

   // a store read is always followed by the pixel capture state
   `ASSERT_NEXT(a_read_then_capture, clock, reset, ram_rd_en, state_ff == nnis_pkg::ST_PIX_READ)
   // the store is never written while a row still awaits output
   `ASSERT_IMPLIES(a_no_write_when_pending, clock, reset, ram_wr_en, !pending_ff)
   // a frame end is always a returned pixel that also ends its row
   `ASSERT_IMPLIES(a_frame_end_is_row_end, clock, reset, rsp_valid_ff && rsp_fend_ff, rsp_rend_ff && rsp_acc_ff)

endmodule

### dv/tb_nearest_neighbor_image_scaler.sv
// testbench for the nearest-neighbour image scaler: directed and random push/pull transfers
// through several register settings, each result checked against a behavioural scoreboard
// depends on nnis_pkg and the nearest_neighbor_image_scaler rtl only

module tb_nearest_neighbor_image_scaler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 2048;
   // a pull may walk up to MAX_W source columns, so the quiet limit sits well above that
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 16;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic                       req_command   = nnis_pkg::CMD_PUSH;
   logic [7:0]                 req_in_blue   = '0;
   logic [7:0]                 req_in_green  = '0;
   logic [7:0]                 req_in_red    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic                       rsp_accepted;
   logic [7:0]                 rsp_out_blue;
   logic [7:0]                 rsp_out_green;
   logic [7:0]                 rsp_out_red;
   logic                       rsp_row_end;
   logic                       rsp_frame_end;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [nnis_pkg::IDX_W-1:0] csr_index     = nnis_pkg::REG_IN_WIDTH;
   logic [nnis_pkg::DIM_W-1:0] csr_data      = '0;

   nearest_neighbor_image_scaler #(.MAX_WIDTH(MAX_W)) DUT (.*);

   // one result transfer, field order matches the rsp_ ports
   typedef struct packed {
      logic       accepted;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       row_end;
      logic       frame_end;
   } pixel_result_type;

   // scoreboard: resampling model plus the queue of results still owed by the block
   class scaler_scoreboard;
      logic [nnis_pkg::COL_W-1:0] in_width;
      logic [nnis_pkg::DIM_W-1:0] in_height, out_width, out_height;
      logic [nnis_pkg::PIX_W-1:0] line_store [MAX_W];
      bit                         ever_written [MAX_W];
      logic [nnis_pkg::COL_W-1:0] push_col, src_col;
      logic [nnis_pkg::DIM_W-1:0] push_row, rows_out, pix_out;
      bit                         row_pending;
      pixel_result_type           owed_results [$];
      int unsigned                mismatches, commands, pixels_out, frames_out, reg_writes;

      function new();
         in_width    = 1;
         in_height   = 1;
         out_width   = 1;
         out_height  = 1;
         push_col    = '0;
         src_col     = '0;
         push_row    = '0;
         rows_out    = '0;
         pix_out     = '0;
         row_pending = 1'b0;
         foreach (ever_written[i]) ever_written[i] = 1'b0;
      endfunction

      function longint unsigned eff_in_w();
         longint unsigned w;
         w = (in_width == 0) ? 1 : in_width;
         return (w > MAX_W) ? MAX_W : w;
      endfunction

      function longint unsigned eff_in_h();
         return (in_height == 0) ? 1 : in_height;
      endfunction

      function longint unsigned eff_out_w();
         return (out_width == 0) ? 1 : out_width;
      endfunction

      function longint unsigned eff_out_h();
         return (out_height == 0) ? 1 : out_height;
      endfunction

      // does the last complete input row owe another output row; wrap the frame if not
      function void settle_rows();
         longint unsigned oh;
         oh = eff_out_h();
         row_pending = (rows_out < oh) && (rows_out * eff_in_h() < oh * push_row);
         if (!row_pending && push_row >= eff_in_h()) begin
            push_row = '0;
            rows_out = '0;
         end
      endfunction

      function void write_reg(logic [nnis_pkg::IDX_W-1:0] idx,
                              logic [nnis_pkg::DIM_W-1:0] data);
         case (idx)
            nnis_pkg::REG_IN_WIDTH:   in_width   = data[nnis_pkg::COL_W-1:0];
            nnis_pkg::REG_IN_HEIGHT:  in_height  = data;
            nnis_pkg::REG_OUT_WIDTH:  out_width  = data;
            nnis_pkg::REG_OUT_HEIGHT: out_height = data;
            default: ;
         endcase
         reg_writes++;
      endfunction

      // widening the row while one is pending could make a pull read a never-written entry
      function bit widening_hazard(longint unsigned raw_w);
         longint unsigned w;
         w = (raw_w == 0) ? 1 : raw_w;
         if (w > MAX_W) w = MAX_W;
         if (!row_pending) return 1'b0;
         for (int i = 0; i < w; i++)
            if (!ever_written[i]) return 1'b1;
         return 1'b0;
      endfunction

      // accepted command: advance the model and queue the result it owes
      function void note_command(logic cmd, logic [7:0] blue, logic [7:0] green,
                                 logic [7:0] red);
         pixel_result_type           res;
         longint unsigned            iw, ow;
         logic [nnis_pkg::PIX_W-1:0] px;
         res = '0;
         iw  = eff_in_w();
         commands++;
         if (cmd == nnis_pkg::CMD_PUSH) begin
            if (!row_pending) begin
               if (push_col < MAX_W) begin
                  line_store[push_col]   = {red, green, blue};
                  ever_written[push_col] = 1'b1;
               end
               res.accepted = 1'b1;
               push_col = push_col + 1'b1;
               if (push_col >= iw) begin
                  push_col = '0;
                  push_row = push_row + 1'b1;
                  pix_out  = '0;
                  src_col  = '0;
                  settle_rows();
               end
            end
         end else if (row_pending) begin
            ow = eff_out_w();
            while ((src_col + 64'd1 < iw) && (pix_out * iw >= ow * (src_col + 64'd1)))
               src_col = src_col + 1'b1;
            px = line_store[src_col];
            res.accepted = 1'b1;
            res.blue     = px[7:0];
            res.green    = px[15:8];
            res.red      = px[23:16];
            pixels_out++;
            pix_out = pix_out + 1'b1;
            if (pix_out >= ow) begin
               res.row_end = 1'b1;
               pix_out  = '0;
               src_col  = '0;
               rows_out = rows_out + 1'b1;
               if (rows_out >= eff_out_h()) begin
                  res.frame_end = 1'b1;
                  frames_out++;
               end
               settle_rows();
            end
         end
         owed_results.push_back(res);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (owed_results.size() == 0) begin
            report_mismatch("result transfer with no command waiting on it");
            return;
         end
         want = owed_results.pop_front();
         compare_field("accepted", got.accepted, want.accepted);
         compare_field("out_blue", got.blue, want.blue);
         compare_field("out_green", got.green, want.green);
         compare_field("out_red", got.red, want.red);
         compare_field("row_end", got.row_end, want.row_end);
         compare_field("frame_end", got.frame_end, want.frame_end);
      endtask
   endclass

   scaler_scoreboard sb;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct     = 0;
   int unsigned      quiet_cycles  = 0;

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: stall decided afresh every cycle, one assignment per edge
   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result monitor: values read here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_pixel(pixel_result_type'({rsp_accepted, rsp_out_blue, rsp_out_green,
                                            rsp_out_red, rsp_row_end, rsp_frame_end}));
   end

   // watchdog: counts cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_nearest_neighbor_image_scaler: FAIL");
         $finish;
      end
   end

   // one command transfer, with an optional idle gap in front of it;
   // valid is left high afterwards so back-to-back transfers need no second assignment
   task automatic send_item(input logic cmd, input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_in_blue  <= blue;
      req_in_green <= green;
      req_in_red   <= red;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_command(cmd, blue, green, red);
   endtask

   task automatic wait_for_results();
      while (sb.owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [nnis_pkg::IDX_W-1:0] idx,
                            input logic [nnis_pkg::DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
   endtask

   // registers change only with nothing in flight; a pending row is pulled out first
   // when the new width would reach store entries that were never written
   task automatic configure(input int unsigned iw, input int unsigned ih,
                            input int unsigned ow, input int unsigned oh);
      if (sb.widening_hazard(iw)) begin
         while (sb.widening_hazard(iw))
            send_item(nnis_pkg::CMD_PULL, 8'($urandom), 8'($urandom), 8'($urandom));
         req_valid <= 1'b0;
         wait_for_results();
      end
      write_reg(nnis_pkg::REG_IN_WIDTH, nnis_pkg::DIM_W'(iw));
      write_reg(nnis_pkg::REG_IN_HEIGHT, nnis_pkg::DIM_W'(ih));
      write_reg(nnis_pkg::REG_OUT_WIDTH, nnis_pkg::DIM_W'(ow));
      write_reg(nnis_pkg::REG_OUT_HEIGHT, nnis_pkg::DIM_W'(oh));
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed traffic: pull while a row is pending, push otherwise,
   // with a share of refused pushes and empty pulls mixed in
   task automatic run_phase(input int unsigned iw, input int unsigned ih,
                            input int unsigned ow, input int unsigned oh,
                            input int unsigned count, input int unsigned send_pct,
                            input int unsigned hold_pct);
      logic cmd;
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      configure(iw, ih, ow, oh);
      repeat (count) begin
         if (sb.row_pending)
            cmd = ($urandom_range(99) < 85) ? nnis_pkg::CMD_PULL : nnis_pkg::CMD_PUSH;
         else
            cmd = ($urandom_range(99) < 85) ? nnis_pkg::CMD_PUSH : nnis_pkg::CMD_PULL;
         send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      req_valid <= 1'b0;
      wait_for_results();
   endtask

   function automatic int unsigned pick_dim(input int unsigned limit);
      // zero now and then, which the block treats as one
      return ($urandom_range(9) == 0) ? 0 : $urandom_range(limit, 1);
   endfunction

   int unsigned send_mix [4] = '{0, 84, 0, 33};
   int unsigned stall_mix [4] = '{0, 0, 84, 33};

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x2 image to 5x3, so each row is stretched and the first
      // input row feeds two output rows
      configure(3, 2, 5, 3);
      // pull with no row pending comes back empty
      send_item(nnis_pkg::CMD_PULL, 8'h5a, 8'ha5, 8'h3c);
      send_item(nnis_pkg::CMD_PUSH, 8'h00, 8'h00, 8'h00);
      send_item(nnis_pkg::CMD_PUSH, 8'hff, 8'hff, 8'hff);
      send_item(nnis_pkg::CMD_PUSH, 8'h12, 8'h34, 8'h56);
      // row pending, so this push is refused
      send_item(nnis_pkg::CMD_PUSH, 8'ha5, 8'h5a, 8'hc3);
      repeat (10) send_item(nnis_pkg::CMD_PULL, 8'hff, 8'h00, 8'hff);
      send_item(nnis_pkg::CMD_PUSH, 8'h81, 8'h42, 8'h24);
      send_item(nnis_pkg::CMD_PUSH, 8'h7e, 8'hbd, 8'hdb);
      send_item(nnis_pkg::CMD_PUSH, 8'h01, 8'h80, 8'hc3);
      // last output row closes the frame and the counters wrap
      repeat (5) send_item(nnis_pkg::CMD_PULL, 8'h00, 8'hff, 8'h00);
      req_valid <= 1'b0;
      wait_for_results();

      // upscale both ways
      run_phase(4, 3, 9, 7, 150, 0, 0);
      // downscale: skipped source columns and input rows giving no output row
      run_phase(8, 6, 3, 2, 150, 84, 0);
      // all registers zero
      run_phase(0, 0, 0, 0, 100, 0, 84);
      // largest heights and output width, rows far too long to finish
      run_phase(3, 65535, 65535, 65535, 120, 33, 33);
      // shrink below the counters left behind: they count as complete
      run_phase(2, 1, 1, 1, 100, 0, 0);
      // width above the store size, clamped to it
      run_phase(4095, 2, 7, 5, 60, 84, 0);
      // narrow again mid-row, so the next push closes the row
      run_phase(6, 5, 13, 11, 120, 0, 84);
      for (int p = 0; p < 6; p++)
         run_phase(pick_dim(12), pick_dim(8), pick_dim(24), pick_dim(16), 100,
                   send_mix[p % 4], stall_mix[p % 4]);
      // exactly the store size
      run_phase(2048, 3, 5, 4, 40, 33, 33);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("scaler run: %0d commands, %0d pixels pulled, %0d frames closed",
               sb.commands, sb.pixels_out, sb.frames_out);
      $display("scaler run: %0d register writes over 15 settings, %0d mismatches",
               sb.reg_writes, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb_nearest_neighbor_image_scaler: PASS");
      else
         $display("tb_nearest_neighbor_image_scaler: FAIL");
      $finish;
   end

endmodule
